### hw/rtl/fmad_pkg.sv
// package for the minutes-to-ascii date block: stamp type, constants, digit helpers
// no dependencies; compiled first

package fmad_pkg;

    localparam int STAMP_DIGITS = 13;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_PAD  = 8'h00;

    // reciprocal multipliers, exact over the ranges they see
    localparam logic [19:0] RECIP_45   = 20'd745655;  // >> 25, numerator below 2^19
    localparam logic [13:0] RECIP_7    = 14'd9363;    // >> 16, numerator below 11652
    localparam logic [13:0] RECIP_1461 = 14'd11484;   // >> 24, numerator below 11651
    localparam logic [10:0] RECIP_60   = 11'd1093;    // >> 16, numerator below 1440

    localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
    localparam logic [10:0] DAYS_PER_CYC = 11'd1461;

    // offsets of years two to four in a four-year cycle that opens with a leap year
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    typedef logic [STAMP_DIGITS-1:0][7:0] stamp_t;

    // day of year at which month idx (0 is january) begins
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && idx >= 4'd2)
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

    // two ascii characters {tens, ones} for a value below 100
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        begin
            prod = 15'(v) * 15'd205;
            tens = prod[14:11];
            ones = v - 7'(tens) * 7'd10;
            return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones[3:0])};
        end
    endfunction

endpackage

### hw/rtl/fmad_if.sv
// channel interfaces: minute count in, ascii bytes out
// depends on nothing; compiled after fmad_pkg

interface fmad_minutes_if;
    logic       valid;
    logic       ready;
    logic [7:0] minutes_byte_low;
    logic [7:0] minutes_byte_mid;
    logic [7:0] minutes_byte_high;

    modport source (output valid, output minutes_byte_low, output minutes_byte_mid,
                    output minutes_byte_high, input ready);
    modport sink   (input valid, input minutes_byte_low, input minutes_byte_mid,
                    input minutes_byte_high, output ready);
endinterface

interface fmad_ascii_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_byte;
    logic [3:0] byte_position;
    logic       last_byte;

    modport source (output valid, output ascii_byte, output byte_position,
                    output last_byte, input ready);
    modport sink   (input valid, input ascii_byte, input byte_position,
                    input last_byte, output ready);
endinterface

### hw/rtl/fmad_calendar_pipe.sv
// five-stage pipeline from a 24-bit minute count to the 13-character date stamp
// depends on fmad_pkg and fmad_minutes_if

module fmad_calendar_pipe
    import fmad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    fmad_minutes_if.sink        minutes,
    output logic                stamp_valid,
    input  logic                stamp_ready,
    output stamp_t              stamp
);

    logic [5:1] v_reg;
    logic [6:1] en;

    // stage 1: days = minutes / 1440
    logic [23:0] s0_mins;
    logic [38:0] s0_prod;
    logic [13:0] s1_days_next, s1_days_reg;
    logic [10:0] s1_mins_lo_reg;

    // stage 2: minute of day, weekday quotient, four-year cycle
    logic [24:0] s1_day_mins;
    logic [13:0] s1_wx;
    logic [27:0] s1_wprod;
    logic [27:0] s1_cprod;
    logic [10:0] s2_mod_next, s2_mod_reg;
    logic [10:0] s2_wq_reg;
    logic [2:0]  s2_cyc_reg;
    logic [13:0] s2_days_reg;

    // stage 3: weekday, year in cycle, day of year, hour
    logic [13:0] s2_wx, s2_w, s2_r_full;
    logic [10:0] s2_r, s2_doy_full;
    logic [1:0]  s2_yi;
    logic [21:0] s2_hprod;
    logic [2:0]  s3_wday_reg;
    logic [4:0]  s3_year_off_reg;
    logic [8:0]  s3_doy_reg;
    logic        s3_leap_reg;
    logic [4:0]  s3_hour_reg;
    logic [10:0] s3_mod_reg;

    // stage 4: month, day, minute
    logic [3:0]  s3_mon_idx;
    logic [8:0]  s3_day_full;
    logic [10:0] s3_min_full;
    logic [3:0]  s4_month_reg;
    logic [4:0]  s4_day_reg;
    logic [4:0]  s4_hour_reg;
    logic [5:0]  s4_minute_reg;
    logic [4:0]  s4_year_off_reg;
    logic [2:0]  s4_wday_reg;

    // stage 5: ascii
    logic [4:0]  s4_y2;
    logic [15:0] s4_year_lo;
    stamp_t      s5_stamp_next, s5_stamp_reg;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[6] = stamp_ready;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign minutes.ready = en[1];
    assign stamp_valid   = v_reg[5];
    assign stamp         = s5_stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= minutes.valid;
            end
            for (int k = 2; k <= 5; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1
    always_comb
    begin
        s0_mins      = {minutes.minutes_byte_high, minutes.minutes_byte_mid,
                        minutes.minutes_byte_low};
        s0_prod      = 39'(s0_mins[23:5]) * 39'(RECIP_45);
        s1_days_next = s0_prod[38:25];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_days_reg    <= s1_days_next;
            s1_mins_lo_reg <= s0_mins[10:0];
        end
    end

    // stage 2: 2000 is a leap year, so every 1461-day cycle from 1996 to 2027 starts leap
    always_comb
    begin
        s1_day_mins = 25'(s1_days_reg) * 25'(MIN_PER_DAY);
        s2_mod_next = s1_mins_lo_reg - s1_day_mins[10:0];
        // weekday of 1996-01-01 is monday: (days + 1) mod 7
        s1_wx       = s1_days_reg + 14'd1;
        s1_wprod    = 28'(s1_wx) * 28'(RECIP_7);
        s1_cprod    = 28'(s1_days_reg) * 28'(RECIP_1461);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_mod_reg  <= s2_mod_next;
            s2_wq_reg   <= s1_wprod[26:16];
            s2_cyc_reg  <= s1_cprod[26:24];
            s2_days_reg <= s1_days_reg;
        end
    end

    // stage 3
    always_comb
    begin
        s2_wx     = s2_days_reg + 14'd1;
        s2_w      = s2_wx - 14'(s2_wq_reg) * 14'd7;
        s2_r_full = s2_days_reg - 14'(s2_cyc_reg) * 14'(DAYS_PER_CYC);
        s2_r      = s2_r_full[10:0];
        if (s2_r < YEAR1_START)
        begin
            s2_yi       = 2'd0;
            s2_doy_full = s2_r;
        end
        else if (s2_r < YEAR2_START)
        begin
            s2_yi       = 2'd1;
            s2_doy_full = s2_r - YEAR1_START;
        end
        else if (s2_r < YEAR3_START)
        begin
            s2_yi       = 2'd2;
            s2_doy_full = s2_r - YEAR2_START;
        end
        else
        begin
            s2_yi       = 2'd3;
            s2_doy_full = s2_r - YEAR3_START;
        end
        s2_hprod = 22'(s2_mod_reg) * 22'(RECIP_60);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_wday_reg     <= s2_w[2:0];
            s3_year_off_reg <= {s2_cyc_reg, s2_yi};
            s3_doy_reg      <= s2_doy_full[8:0];
            s3_leap_reg     <= (s2_yi == 2'd0);
            s3_hour_reg     <= s2_hprod[20:16];
            s3_mod_reg      <= s2_mod_reg;
        end
    end

    // stage 4: month starts rise, so the last one passed wins
    always_comb
    begin
        s3_mon_idx = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (s3_doy_reg >= month_start(4'(i), s3_leap_reg))
            begin
                s3_mon_idx = 4'(i);
            end
        end
        s3_day_full = s3_doy_reg - month_start(s3_mon_idx, s3_leap_reg) + 9'd1;
        s3_min_full = s3_mod_reg - 11'(s3_hour_reg) * 11'd60;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_month_reg    <= s3_mon_idx + 4'd1;
            s4_day_reg      <= s3_day_full[4:0];
            s4_hour_reg     <= s3_hour_reg;
            s4_minute_reg   <= s3_min_full[5:0];
            s4_year_off_reg <= s3_year_off_reg;
            s4_wday_reg     <= s3_wday_reg;
        end
    end

    // stage 5
    always_comb
    begin
        s4_y2 = s4_year_off_reg - 5'd4;
        if (s4_year_off_reg < 5'd4)
        begin
            s5_stamp_next[0] = ASCII_ZERO + 8'd1;
            s5_stamp_next[1] = ASCII_ZERO + 8'd9;
            s4_year_lo       = {ASCII_ZERO + 8'd9,
                                ASCII_ZERO + 8'd6 + 8'(s4_year_off_reg[1:0])};
        end
        else
        begin
            s5_stamp_next[0] = ASCII_ZERO + 8'd2;
            s5_stamp_next[1] = ASCII_ZERO;
            s4_year_lo       = two_digits(7'(s4_y2));
        end
        s5_stamp_next[2]  = s4_year_lo[15:8];
        s5_stamp_next[3]  = s4_year_lo[7:0];
        {s5_stamp_next[4], s5_stamp_next[5]}   = two_digits(7'(s4_month_reg));
        {s5_stamp_next[6], s5_stamp_next[7]}   = two_digits(7'(s4_day_reg));
        {s5_stamp_next[8], s5_stamp_next[9]}   = two_digits(7'(s4_hour_reg));
        {s5_stamp_next[10], s5_stamp_next[11]} = two_digits(7'(s4_minute_reg));
        s5_stamp_next[12] = ASCII_ZERO + 8'(s4_wday_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_stamp_reg <= s5_stamp_next;
        end
    end

endmodule

### hw/rtl/fmad_byte_serializer.sv
// sends a date stamp out one byte per transaction, then zero padding
// depends on fmad_pkg and fmad_ascii_if

module fmad_byte_serializer
    import fmad_pkg::*;
#(
    parameter int RESULT_BYTES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          stamp_valid,
    output logic          stamp_ready,
    input  stamp_t        stamp,
    fmad_ascii_if.source  ascii
);

    localparam int CW = $clog2(RESULT_BYTES);
    localparam logic [CW-1:0] LAST_POS = CW'(RESULT_BYTES - 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] pos_reg, pos_next;
    stamp_t        stamp_reg;
    logic          fire, is_last, load;

    assign fire        = busy_reg && ascii.ready;
    assign is_last     = (pos_reg == LAST_POS);
    assign stamp_ready = !busy_reg || (ascii.ready && is_last);
    assign load        = stamp_valid && stamp_ready;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
        else if (fire)
        begin
            busy_next = !is_last;
            pos_next  = pos_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stamp_reg <= stamp;
        end
    end

    assign ascii.valid         = busy_reg;
    assign ascii.ascii_byte    = (pos_reg < CW'(STAMP_DIGITS)) ? stamp_reg[pos_reg[3:0]]
                                                               : ASCII_PAD;
    assign ascii.byte_position = pos_reg[3:0];
    assign ascii.last_byte     = is_last;

endmodule

### hw/rtl/fru_minutes_to_ascii_date.sv
// top level: minutes since 1996-01-01 to an ascii date stamp "YYYYMMDDhhmmW" plus padding
// depends on fmad_pkg, fmad_if, fmad_calendar_pipe and fmad_byte_serializer

// Each transaction on minutes carries a 24-bit count of minutes since 1996-01-01 00:00,
// in three byte fields, and yields RESULT_BYTES transactions on ascii: year, month, day,
// hour and minute as twelve ascii digits, the weekday digit (0 is sunday), then 0x00
// padding, with byte_position counting modulo 16 and last_byte on the final one. The
// conversion runs in a five-stage pipeline (division by 1440 through a reciprocal multiply,
// minute of day with the weekday and four-year cycle, year and day of year with the hour,
// month and day with the minute, then ascii), and each stamp is then loaded into the byte
// serializer before its first byte is offered. The serializer sets the throughput: it takes a
// new stamp only when idle or on the handshake of the last byte of the one before, while up
// to five further inputs are taken and converted as the current stamp is still going out.
// There is no state across inputs and no configuration.

module fru_minutes_to_ascii_date
    import fmad_pkg::*;
#(
    parameter int RESULT_BYTES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    fmad_minutes_if.sink  minutes,
    fmad_ascii_if.source  ascii
);

    // byte_position carried on the last byte of a run
    localparam logic [3:0] LAST_POS = 4'((RESULT_BYTES - 1) % 16);

    logic   stamp_valid;
    logic   stamp_ready;
    stamp_t stamp;

    // calendar arithmetic, one input per cycle when the output keeps up
    fmad_calendar_pipe u_calendar_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .minutes     (minutes),
        .stamp_valid (stamp_valid),
        .stamp_ready (stamp_ready),
        .stamp       (stamp)
    );

    // one byte per output transaction, next stamp loads on the last byte's handshake
    fmad_byte_serializer #(
        .RESULT_BYTES (RESULT_BYTES)
    ) u_byte_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .stamp_valid (stamp_valid),
        .stamp_ready (stamp_ready),
        .stamp       (stamp),
        .ascii       (ascii)
    );

    // the last byte flag only ever sits on the final position
    assert property (@(posedge clk) disable iff (!rst_n)
        ascii.valid && ascii.last_byte |-> ascii.byte_position == LAST_POS)
        else $error("last_byte away from final position");

    // a run keeps going until its last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        ascii.valid && ascii.ready && !ascii.last_byte |=> ascii.valid)
        else $error("byte run broken off early");

    // positions step by one within a run
    assert property (@(posedge clk) disable iff (!rst_n)
        ascii.valid && ascii.ready && !ascii.last_byte
        |=> ascii.byte_position == $past(ascii.byte_position) + 4'd1)
        else $error("byte position skipped");

endmodule

### tb/fmad_cal_pkg.sv
`timescale 1ns / 1ps
// calendar helpers for the testbench: leap rule, month lengths, minute count of a date
// no dependencies; compiled before the checker and the testbench top

package fmad_cal_pkg;

    localparam int FIRST_YEAR = 1996;

    function automatic bit year_has_leap_day(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_length(input int y, input int m);
        int lengths [12];
        begin
            lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m == 2 && year_has_leap_day(y))
            begin
                return 29;
            end
            return lengths[m - 1];
        end
    endfunction

    // minutes since 1996-01-01 00:00 of the given date and time
    function automatic int minutes_at(input int y, input int mo, input int d,
                                      input int h, input int mi);
        int days;
        begin
            days = 0;
            for (int yy = FIRST_YEAR; yy < y; yy++)
            begin
                days += year_has_leap_day(yy) ? 366 : 365;
            end
            for (int mm = 1; mm < mo; mm++)
            begin
                days += month_length(y, mm);
            end
            days += d - 1;
            return days * 1440 + h * 60 + mi;
        end
    endfunction

endpackage

### tb/fmad_stamp_checker.sv
`timescale 1ns / 1ps
// checker for the minutes-to-ascii date block: predicts each stamp and compares the bytes
// depends on fmad_pkg, fmad_if and fmad_cal_pkg

module fmad_stamp_checker
    import fmad_pkg::*;
    import fmad_cal_pkg::*;
#(
    parameter int RESULT_BYTES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    fmad_minutes_if minutes,
    fmad_ascii_if   ascii,
    output int      fail_count,
    output int      pending
);

    typedef struct packed {
        logic [7:0] ascii_byte;
        logic [3:0] byte_position;
        logic       last_byte;
    } ascii_beat_t;

    typedef logic [7:0] date_text_t [STAMP_DIGITS];

    ascii_beat_t expected_bytes_q [$];
    ascii_beat_t got_beat;
    ascii_beat_t want_beat;
    date_text_t  text;

    function automatic logic [7:0] digit(input int v);
        return ASCII_ZERO + 8'(v);
    endfunction

    // "YYYYMMDDhhmmW" for a count of minutes since 1996-01-01
    function automatic date_text_t date_text_of(input logic [23:0] count);
        int         days;
        int         minute_of_day;
        int         weekday;
        int         year;
        int         month;
        int         day;
        date_text_t txt;
        begin
            days          = count / 1440;
            minute_of_day = count % 1440;
            // 9496 days from 1970, which opened on a thursday
            weekday       = (days + 9496 + 4) % 7;
            year          = FIRST_YEAR;
            month         = 1;
            while (days >= (year_has_leap_day(year) ? 366 : 365))
            begin
                days -= year_has_leap_day(year) ? 366 : 365;
                year++;
            end
            while (month < 12 && days >= month_length(year, month))
            begin
                days -= month_length(year, month);
                month++;
            end
            day     = days + 1;
            txt[0]  = digit((year / 1000) % 10);
            txt[1]  = digit((year / 100) % 10);
            txt[2]  = digit((year / 10) % 10);
            txt[3]  = digit(year % 10);
            txt[4]  = digit(month / 10);
            txt[5]  = digit(month % 10);
            txt[6]  = digit(day / 10);
            txt[7]  = digit(day % 10);
            txt[8]  = digit((minute_of_day / 60) / 10);
            txt[9]  = digit((minute_of_day / 60) % 10);
            txt[10] = digit((minute_of_day % 60) / 10);
            txt[11] = digit((minute_of_day % 60) % 10);
            txt[12] = digit(weekday);
            return txt;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (minutes.valid && minutes.ready)
            begin
                text = date_text_of({minutes.minutes_byte_high, minutes.minutes_byte_mid,
                                     minutes.minutes_byte_low});
                for (int k = 0; k < RESULT_BYTES; k++)
                begin
                    expected_bytes_q.push_back('{(k < STAMP_DIGITS) ? text[k] : ASCII_PAD,
                                                 4'(k), k == RESULT_BYTES - 1});
                end
            end
            if (ascii.valid && ascii.ready)
            begin
                got_beat = '{ascii.ascii_byte, ascii.byte_position, ascii.last_byte};
                if (expected_bytes_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected ascii transaction: byte %h position %0d last %b",
                                 got_beat.ascii_byte, got_beat.byte_position,
                                 got_beat.last_byte);
                    end
                end
                else
                begin
                    want_beat = expected_bytes_q.pop_front();
                    if (got_beat.ascii_byte !== want_beat.ascii_byte ||
                        got_beat.byte_position !== want_beat.byte_position ||
                        got_beat.last_byte !== want_beat.last_byte)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch: expected byte %h position %0d last %b, %s %h %0d %b",
                                     want_beat.ascii_byte, want_beat.byte_position,
                                     want_beat.last_byte, "got", got_beat.ascii_byte,
                                     got_beat.byte_position, got_beat.last_byte);
                        end
                    end
                end
            end
            pending = expected_bytes_q.size();
        end
    end

endmodule

### tb/tb_fru_minutes_to_ascii_date.sv
`timescale 1ns / 1ps
// testbench top for fru_minutes_to_ascii_date: drives minute counts, stalls the byte output
// depends on fmad_pkg, fmad_if, fmad_cal_pkg, fmad_stamp_checker and the block itself

module tb_fru_minutes_to_ascii_date;
    import fmad_cal_pkg::*;

    localparam int RESULT_BYTES  = 16;
    localparam int RANDOM_COUNTS = 128;
    // long receiver hold-off, enough for the pipeline and serializer to fill up
    localparam int HOLD_CYCLES   = 300;
    // several times the longest quiet stretch of a correct run
    localparam int IDLE_LIMIT    = 3000;
    // pipeline latency plus a full stamp, with margin
    localparam int DRAIN_CYCLES  = 2 * RESULT_BYTES + 8;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   steady;     // no idling on either side
    bit   burst;      // sender offers back to back
    bit   hold_req;   // receiver to hold off for HOLD_CYCLES

    fmad_minutes_if minutes_ch ();
    fmad_ascii_if   ascii_ch ();

    fru_minutes_to_ascii_date #(
        .RESULT_BYTES (RESULT_BYTES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .minutes (minutes_ch),
        .ascii   (ascii_ch)
    );

    fmad_stamp_checker #(
        .RESULT_BYTES (RESULT_BYTES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .minutes    (minutes_ch),
        .ascii      (ascii_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (steady || r < 55)
            begin
                return 0;
            end
            if (r < 85)
            begin
                return $urandom_range(1, 3);
            end
            if (r < 97)
            begin
                return $urandom_range(4, 12);
            end
            return $urandom_range(20, 60);
        end
    endfunction

    // offer one minute count and wait for its transaction
    task automatic offer_count(input logic [23:0] count);
        int n;
        begin
            n = burst ? 0 : gap_len();
            if (n > 0)
            begin
                minutes_ch.valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            minutes_ch.valid <= 1'b1;
            {minutes_ch.minutes_byte_high, minutes_ch.minutes_byte_mid,
             minutes_ch.minutes_byte_low} <= count;
            @(posedge clk);
            while (!minutes_ch.ready)
            begin
                @(posedge clk);
            end
        end
    endtask

    // sender goes quiet until every predicted byte has arrived, then lets the pipe settle
    task automatic drain_results();
        begin
            minutes_ch.valid <= 1'b0;
            // wait for an edge first so the checker has booked the last transaction
            @(posedge clk);
            while (pending != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((minutes_ch.valid && minutes_ch.ready) || (ascii_ch.valid && ascii_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("fru_minutes_to_ascii_date test failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req)
            begin
                ascii_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    ascii_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                ascii_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [23:0] directed_counts [$];
        int          kind;
        int          y;
        int          m;
        int          v;
        logic [23:0] count;

        steady      = 1'b0;
        burst       = 1'b0;
        hold_req    = 1'b0;
        rst_n                         <= 1'b0;
        minutes_ch.valid              <= 1'b0;
        minutes_ch.minutes_byte_low   <= 8'h00;
        minutes_ch.minutes_byte_mid   <= 8'h00;
        minutes_ch.minutes_byte_high  <= 8'h00;
        ascii_ch.ready                <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes and alternating bit patterns
        directed_counts.push_back(24'h000000);
        directed_counts.push_back(24'hffffff);
        directed_counts.push_back(24'haaaaaa);
        directed_counts.push_back(24'h555555);
        directed_counts.push_back(24'h00ff00);
        directed_counts.push_back(24'hff00ff);
        // end of the first day and start of the second
        directed_counts.push_back(24'd1439);
        directed_counts.push_back(24'd1440);
        // leap day in an ordinary leap year, then year end of that leap year
        directed_counts.push_back(24'(minutes_at(1996, 2, 28, 23, 59)));
        directed_counts.push_back(24'(minutes_at(1996, 2, 29, 0, 0)));
        directed_counts.push_back(24'(minutes_at(1996, 3, 1, 0, 0)));
        directed_counts.push_back(24'(minutes_at(1996, 12, 31, 23, 59)));
        directed_counts.push_back(24'(minutes_at(1997, 1, 1, 0, 0)));
        // february of a common year rolls straight into march
        directed_counts.push_back(24'(minutes_at(1997, 2, 28, 12, 30)));
        directed_counts.push_back(24'(minutes_at(1997, 3, 1, 0, 0)));
        directed_counts.push_back(24'(minutes_at(1999, 12, 31, 23, 59)));
        // century year divisible by 400 is a leap year
        directed_counts.push_back(24'(minutes_at(2000, 2, 29, 6, 7)));
        directed_counts.push_back(24'(minutes_at(2000, 12, 31, 23, 59)));
        directed_counts.push_back(24'(minutes_at(2001, 1, 1, 0, 0)));
        // thirty-day month end
        directed_counts.push_back(24'(minutes_at(2004, 4, 30, 23, 59)));
        directed_counts.push_back(24'(minutes_at(2024, 2, 29, 10, 10)));
        // last year the 24-bit count reaches
        directed_counts.push_back(24'(minutes_at(2027, 1, 1, 0, 0)));
        foreach (directed_counts[i])
        begin
            offer_count(directed_counts[i]);
        end
        drain_results();

        for (int i = 0; i < RANDOM_COUNTS; i++)
        begin
            // alternate phases with and without idling
            if (i % 25 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
            end
            // receiver holds off while the sender keeps offering, so the block fills up
            if (i == 40)
            begin
                hold_req = 1'b1;
                burst    = 1'b1;
            end
            if (i == 52)
            begin
                burst = 1'b0;
            end
            if (i == 90)
            begin
                drain_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                count = 24'($urandom);
            end
            else if (kind < 85)
            begin
                // around the start of a random month: month, year and leap-day edges
                y = $urandom_range(FIRST_YEAR, 2026);
                m = $urandom_range(1, 12);
                v = minutes_at(y, m, 1, 0, 0);
                if ($urandom_range(0, 1) == 1 || v < 3)
                begin
                    v = v + $urandom_range(0, 2);
                end
                else
                begin
                    v = v - $urandom_range(1, 3);
                end
                count = 24'(v);
            end
            else if (kind < 93)
            begin
                count = 24'($urandom_range(0, 2880));
            end
            else
            begin
                count = 24'hffffff - 24'($urandom_range(0, 3000));
            end
            offer_count(count);
        end
        drain_results();

        if (fail_count == 0 && pending == 0)
        begin
            $display("fru_minutes_to_ascii_date test passed");
        end
        else
        begin
            $display("fru_minutes_to_ascii_date test failed");
        end
        $finish;
    end

endmodule
